/* hw/rtl/glyph_column_renderer_assert.svh */
// Assertion helpers used by the RTL of the glyph column renderer.
`ifndef GLYPH_COLUMN_RENDERER_ASSERT_SVH
`define GLYPH_COLUMN_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gcr_pkg.sv */
package gcr_pkg;

  // Request fields of one input item.
  typedef struct packed {
    logic       kind;
    logic [8:0] char_code;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] fore_color;
    logic [7:0] back_color;
    logic [10:0] font_addr;
    logic [7:0] font_byte;
  } gcr_in_t;

  // Fields of one pixel write.
  typedef struct packed {
    logic [19:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        last;
  } gcr_out_t;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_GLYPH_BYTES  = 3'd2;
  localparam logic [2:0] CFG_SCREEN_WIDTH = 3'd3;

  // Microcode step addresses.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_COL    = 3'd3;
  localparam logic [2:0] ST_PIX    = 3'd4;
  localparam logic [2:0] ST_LOAD   = 3'd5;

  // Datapath operations.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_SETUP = 3'd1;
  localparam logic [2:0] OP_BASE  = 3'd2;
  localparam logic [2:0] OP_COL   = 3'd3;
  localparam logic [2:0] OP_PIX   = 3'd4;
  localparam logic [2:0] OP_WRITE = 3'd5;

  // Jump conditions.
  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_NO_START = 3'd1;
  localparam logic [2:0] C_LOAD     = 3'd2;
  localparam logic [2:0] C_SKIP     = 3'd3;
  localparam logic [2:0] C_COL_DONE = 3'd4;
  localparam logic [2:0] C_ROW_MORE = 3'd5;

  // One control word: operation, jump condition, jump target, fall-through step.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cond;
    logic [2:0] target;
    logic [2:0] next_step;
  } gcr_ucode_t;

  // Control program. A true condition jumps to target, else to next_step.
  function automatic gcr_ucode_t gcr_ucode_rom(input logic [2:0] step);
    gcr_ucode_t w;
    unique case (step)
      ST_IDLE:   w = '{OP_NONE,  C_NO_START, ST_IDLE, ST_DECODE};
      ST_DECODE: w = '{OP_SETUP, C_LOAD,     ST_LOAD, ST_CHECK};
      ST_CHECK:  w = '{OP_BASE,  C_SKIP,     ST_IDLE, ST_COL};
      ST_COL:    w = '{OP_COL,   C_COL_DONE, ST_IDLE, ST_PIX};
      ST_PIX:    w = '{OP_PIX,   C_ROW_MORE, ST_PIX,  ST_COL};
      ST_LOAD:   w = '{OP_WRITE, C_ALWAYS,   ST_IDLE, ST_IDLE};
      default:   w = '{OP_NONE,  C_ALWAYS,   ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/glyph_column_renderer.sv */
// Glyph column renderer: turns column-major font glyphs into framebuffer pixel writes.
// Input channel: a request is taken when start is high and busy is low. A load request
// writes one byte of the font store and keeps busy high through the DECODE and LOAD
// steps. A draw request keeps busy high through DECODE and CHECK, then through a COL
// step and one PIX step per row for each column of the clamped glyph, then a closing COL
// step; codes above 255 or an empty glyph end after CHECK. Each glyph column fetches its
// font byte from the single font store read port in its COL step, then one pixel per row.
// Result channel: out_strobe is high for exactly one cycle per pixel, with out_data
// holding address, color and the last flag. The first pixel is registered out of the
// first PIX step, after the DECODE, CHECK and COL steps; pixels follow one per cycle within
// a column. The receiver cannot stall: every pixel strobed is taken.
// Configuration channel: cfg_ready is always high; registers should be written only
// while busy is low and no pixel is still going out.
// Reset (synchronous, rst_n low) returns the sequencer to idle and loads the
// register defaults 8, 8, 8 and 320. The font store is not cleared: draw only
// characters whose bytes have been loaded.
`include "glyph_column_renderer_assert.svh"

module glyph_column_renderer
  import gcr_pkg::*;
#(
  parameter int GLYPH_MAX_W = 8,
  parameter int GLYPH_MAX_H = 8,
  parameter int FONT_BYTES  = 2048,
  parameter int ADDR_BITS   = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  gcr_in_t    in_data,
  output logic       out_strobe,
  output gcr_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int FB_AW = $clog2(FONT_BYTES);
  localparam int OUT_BITS = (ADDR_BITS < 20) ? ADDR_BITS : 20;
  localparam logic [19:0] ADDR_MASK = 20'((64'd1 << OUT_BITS) - 64'd1);
  localparam logic [3:0] MAX_W = 4'(GLYPH_MAX_W);
  localparam logic [3:0] MAX_H = 4'(GLYPH_MAX_H);
  localparam logic [12:0] FB_LIMIT = 13'(FONT_BYTES);

  logic [3:0]  glyph_width_r;
  logic [3:0]  glyph_height_r;
  logic [3:0]  glyph_bytes_r;
  logic [9:0]  screen_width_r;

  logic [2:0]  pc_r;
  logic [2:0]  pc_nxt;
  gcr_ucode_t  uw;
  logic        cond_true;
  logic        accept;

  gcr_in_t     item_r;
  logic [3:0]  w_r;
  logic [3:0]  h_r;
  logic [19:0] prod_r;
  logic [12:0] gaddr_r;
  logic [19:0] colbase_r;
  logic [19:0] pix_r;
  logic [3:0]  col_r;
  logic [3:0]  row_r;

  logic [12:0] rd_sum;
  logic        rd_oor;
  logic        wr_ok;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [7:0]  col_bits;
  logic        row_last;
  logic        col_last;

  gcr_out_t    out_r;
  logic        out_strobe_r;

  assign accept    = start && !busy;
  assign busy      = (pc_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= 4'd8;
      glyph_height_r <= 4'd8;
      glyph_bytes_r  <= 4'd8;
      screen_width_r <= 10'd320;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[3:0];
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[3:0];
        CFG_GLYPH_BYTES:  glyph_bytes_r  <= cfg_data[3:0];
        CFG_SCREEN_WIDTH: screen_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fetch the control word and evaluate its jump condition.
  assign uw       = gcr_ucode_rom(pc_r);
  assign row_last = (row_r + 4'd1) == h_r;
  assign col_last = (col_r + 4'd1) == w_r;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_START: cond_true = !start;
      C_LOAD:     cond_true = (item_r.kind == KIND_LOAD);
      C_SKIP:     cond_true = item_r.char_code[8] || (w_r == 4'd0) || (h_r == 4'd0);
      C_COL_DONE: cond_true = (col_r == w_r);
      C_ROW_MORE: cond_true = !row_last;
      default:    cond_true = 1'b1;
    endcase
    pc_nxt = cond_true ? uw.target : uw.next_step;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Datapath driven by the control word.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    unique case (uw.op)
      OP_SETUP: begin
        w_r     <= (glyph_width_r > MAX_W) ? MAX_W : glyph_width_r;
        h_r     <= (glyph_height_r > MAX_H) ? MAX_H : glyph_height_r;
        prod_r  <= {10'd0, item_r.pos_y} * {10'd0, screen_width_r};
        gaddr_r <= {9'd0, glyph_bytes_r} * {4'd0, item_r.char_code};
      end
      OP_BASE: begin
        colbase_r <= prod_r + {10'd0, item_r.pos_x};
        col_r     <= 4'd0;
      end
      OP_COL: begin
        pix_r <= colbase_r;
        row_r <= 4'd0;
      end
      OP_PIX: begin
        pix_r <= pix_r + {10'd0, screen_width_r};
        row_r <= row_r + 4'd1;
        if (row_last) begin
          colbase_r <= colbase_r + 20'd1;
          col_r     <= col_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // Font store: column byte address follows the column counter.
  assign rd_sum   = gaddr_r + {9'd0, col_r};
  assign rd_oor   = (rd_sum >= FB_LIMIT);
  assign wr_ok    = ({2'd0, item_r.font_addr} < FB_LIMIT);
  assign ram_we   = (uw.op == OP_WRITE) && wr_ok;
  assign col_bits = rd_oor ? 8'd0 : ram_rdata;

  gcr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (FB_AW'(item_r.font_addr)),
    .wdata (item_r.font_byte),
    .raddr (FB_AW'(rd_sum)),
    .rdata (ram_rdata)
  );

  // Output register: one pixel per PIX step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (uw.op == OP_PIX);
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_PIX) begin
      out_r.pixel_address <= pix_r & ADDR_MASK;
      out_r.pixel_color   <= col_bits[row_r[2:0]] ? item_r.fore_color : item_r.back_color;
      out_r.last          <= row_last && col_last;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // Checks on sequencing.
  `GCR_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "request taken but not busy")
  `GCR_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy, "pixel out while idle")
  `GCR_ASSERT_NEXT(a_last_ends, clk, rst_n, out_strobe && out_data.last, !out_strobe,
                   "pixel after last")
  `GCR_ASSERT_NOW(a_pix_range, clk, rst_n, pc_r == ST_PIX, (row_r < h_r) && (col_r < w_r),
                  "pixel counters out of glyph")

endmodule

/* hw/rtl/gcr_ram.sv */
module gcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* dv/glyph_pixel_checker.sv */
`timescale 1ns / 100ps

// Watches the request, pixel and register channels of the glyph renderer,
// predicts the pixel writes of every draw request and compares them in order.
module glyph_pixel_checker
  import gcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  gcr_in_t    in_data,
  input  logic       out_strobe,
  input  gcr_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  output int         pixels_pending,
  output int         mismatch_count
);

  localparam int unsigned MAX_COLS    = 8;
  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned STORE_BYTES = 2048;

  // Shadow copy of the register file and the font store.
  logic [3:0] glyph_w;
  logic [3:0] glyph_h;
  logic [3:0] glyph_b;
  logic [9:0] row_stride;
  logic [7:0] font_copy [STORE_BYTES];

  // Pixel writes still to come, oldest first.
  gcr_out_t expected_pixels [$];

  int errors = 0;
  int pending_now = 0;

  assign mismatch_count = errors;
  assign pixels_pending = pending_now;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what);
    $display("%0d ns: pixel check: %s", $time, what);
    errors++;
  endtask

  // Expands one draw request into the pixel writes it must produce.
  function automatic void render_glyph_pixels(input gcr_in_t req);
    int unsigned cols;
    int unsigned rows;
    int unsigned stride;
    int unsigned base;
    int unsigned byte_addr;
    int unsigned addr;
    logic [7:0]  column_bits;
    gcr_out_t    pix;
    if (req.char_code > 9'd255) begin
      return;
    end
    // Oversized glyphs saturate to the 8x8 cell.
    cols = glyph_w;
    rows = glyph_h;
    if (cols > MAX_COLS) cols = MAX_COLS;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    if (cols == 0 || rows == 0) begin
      return;
    end
    stride = row_stride;
    base = int'(req.pos_y) * stride + int'(req.pos_x);
    for (int unsigned c = 0; c < cols; c++) begin
      // Column bytes past the end of the store read as blank.
      byte_addr = int'(glyph_b) * int'(req.char_code) + c;
      column_bits = (byte_addr < STORE_BYTES) ? font_copy[byte_addr] : 8'h00;
      for (int unsigned r = 0; r < rows; r++) begin
        addr = base + c + r * stride;
        pix.pixel_address = 20'(addr);
        pix.pixel_color = column_bits[r] ? req.fore_color : req.back_color;
        pix.last = (c == cols - 1) && (r == rows - 1);
        expected_pixels.push_back(pix);
      end
    end
  endfunction

  always @(posedge clk) begin
    gcr_out_t want;
    if (!rst_n) begin
      glyph_w = 4'd8;
      glyph_h = 4'd8;
      glyph_b = 4'd8;
      row_stride = 10'd320;
      expected_pixels.delete();
    end else begin
      // Every strobed pixel is matched against the oldest expected write.
      if (out_strobe !== 1'b0) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel at %05h color %02h with none expected",
                                    out_data.pixel_address, out_data.pixel_color));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_address !== want.pixel_address) begin
            report_mismatch($sformatf("address %05h, expected %05h",
                                      out_data.pixel_address, want.pixel_address));
          end
          if (out_data.pixel_color !== want.pixel_color) begin
            report_mismatch($sformatf("color %02h at %05h, expected %02h",
                                      out_data.pixel_color, want.pixel_address,
                                      want.pixel_color));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("last flag %b at %05h, expected %b",
                                      out_data.last, want.pixel_address, want.last));
          end
        end
      end

      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GLYPH_WIDTH:  glyph_w = cfg_data[3:0];
          CFG_GLYPH_HEIGHT: glyph_h = cfg_data[3:0];
          CFG_GLYPH_BYTES:  glyph_b = cfg_data[3:0];
          CFG_SCREEN_WIDTH: row_stride = cfg_data;
          default: ;
        endcase
      end

      // Accepted requests: loads update the store, draws queue their pixels.
      if (start && !busy) begin
        if (in_data.kind == KIND_LOAD) begin
          font_copy[in_data.font_addr] = in_data.font_byte;
        end else begin
          render_glyph_pixels(in_data);
        end
      end
    end
    pending_now <= expected_pixels.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import gcr_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int unsigned STORE_BYTES     = 2048;
  localparam int          TARGET_REQUESTS = 270;
  // Column bytes of the first glyph: blank, solid, stripes, single rows, half columns.
  localparam logic [63:0] EDGE_COLUMNS    = 64'hF0_0F_80_01_AA_55_FF_00;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  gcr_in_t    in_data = '0;
  logic       out_strobe;
  gcr_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_GLYPH_WIDTH;
  logic [9:0] cfg_data = '0;

  int pixels_pending;
  int mismatch_count;
  int cycle_count = 0;
  int sent_count = 0;
  bit pauses_on = 1'b0;

  // Which font bytes hold data, and the glyph geometry last written.
  bit         font_loaded [STORE_BYTES];
  logic [3:0] cur_w = 4'd8;
  logic [3:0] cur_h = 4'd8;
  logic [3:0] cur_b = 4'd8;

  glyph_column_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  glyph_pixel_checker pixel_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixels_pending (pixels_pending),
    .mismatch_count (mismatch_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic gcr_in_t random_request();
    return gcr_in_t'({$urandom(), $urandom(), 1'($urandom())});
  endfunction

  // Hands one request to the block and returns at the edge that takes it.
  task automatic issue(input gcr_in_t req);
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    if (req.kind == KIND_LOAD) begin
      font_loaded[req.font_addr] = 1'b1;
    end
    sent_count++;
    // Occasional gap before the next request.
    if (pauses_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic load_font(input logic [10:0] addr, input logic [7:0] value);
    gcr_in_t req;
    req = random_request();
    req.kind = KIND_LOAD;
    req.font_addr = addr;
    req.font_byte = value;
    issue(req);
  endtask

  // Draws one glyph, first loading any of its column bytes not yet written.
  task automatic draw_glyph(input logic [8:0] code, input logic [9:0] x, input logic [9:0] y,
                            input logic [7:0] fore, input logic [7:0] back);
    int unsigned cols;
    int unsigned byte_addr;
    gcr_in_t     req;
    cols = (cur_w > 4'd8) ? 8 : int'(cur_w);
    if (code <= 9'd255 && cur_h != 4'd0) begin
      for (int unsigned c = 0; c < cols; c++) begin
        byte_addr = int'(cur_b) * int'(code) + c;
        if (byte_addr < STORE_BYTES && !font_loaded[byte_addr]) begin
          load_font(11'(byte_addr), 8'($urandom()));
        end
      end
    end
    req = random_request();
    req.kind = KIND_DRAW;
    req.char_code = code;
    req.pos_x = x;
    req.pos_y = y;
    req.fore_color = fore;
    req.back_color = back;
    issue(req);
  endtask

  // Waits until the block is idle and every expected pixel has arrived.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0 || pixels_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Unused upper bits of a 4-bit register, now and then set.
  function automatic logic [5:0] spare_bits();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'd0;
  endfunction

  task automatic apply_settings(input logic [3:0] w, input logic [3:0] h,
                                input logic [3:0] b, input logic [9:0] sw);
    settle();
    write_reg(CFG_GLYPH_WIDTH, {spare_bits(), w});
    write_reg(CFG_GLYPH_HEIGHT, {spare_bits(), h});
    write_reg(CFG_GLYPH_BYTES, {spare_bits(), b});
    write_reg(CFG_SCREEN_WIDTH, sw);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
    cur_b = b;
  endtask

  // Glyph dimension: mostly in range, sometimes empty or oversized.
  function automatic logic [3:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 4'd0;
    if (roll < 22) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  // One setting of the registers followed by a burst of random requests,
  // cut short once the request target is reached.
  task automatic random_phase(input int requests);
    logic [3:0]  w;
    logic [3:0]  h;
    logic [3:0]  b;
    logic [9:0]  sw;
    int unsigned roll;
    w = pick_dim();
    h = pick_dim();
    b = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom());
    case ($urandom_range(0, 7))
      0: sw = 10'd0;
      1: sw = 10'd1;
      2: sw = 10'd1023;
      default: sw = 10'($urandom());
    endcase
    apply_settings(w, h, b, sw);
    for (int i = 0; i < requests && sent_count < TARGET_REQUESTS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        draw_glyph(9'($urandom_range(0, 255)), 10'($urandom()), 10'($urandom()),
                   8'($urandom()), 8'($urandom()));
      end else if (roll < 85) begin
        load_font(11'($urandom_range(0, 2047)), 8'($urandom()));
      end else begin
        draw_glyph(9'($urandom_range(256, 511)), 10'($urandom()), 10'($urandom()),
                   8'($urandom()), 8'($urandom()));
      end
    end
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: patterned glyph at the origin, codes past the font.
    for (int i = 0; i < 8; i++) begin
      load_font(11'(i), EDGE_COLUMNS[8*i +: 8]);
    end
    draw_glyph(9'd0, 10'd0, 10'd0, 8'hFF, 8'h00);
    draw_glyph(9'd256, 10'd0, 10'd0, 8'hFF, 8'h00);
    draw_glyph(9'd511, 10'd1023, 10'd1023, 8'hFF, 8'hFF);

    // Widest stride at the far corner: addresses wrap around.
    apply_settings(4'd8, 4'd8, 4'd8, 10'd1023);
    draw_glyph(9'd0, 10'd1023, 10'd1023, 8'h00, 8'hFF);

    // Single-pixel glyph, last code, last store byte.
    apply_settings(4'd1, 4'd1, 4'd1, 10'd1);
    draw_glyph(9'd255, 10'd5, 10'd7, 8'h5A, 8'hA5);
    load_font(11'd2047, 8'hFF);

    // Empty glyphs draw nothing.
    apply_settings(4'd0, 4'd8, 4'd8, 10'd320);
    draw_glyph(9'd0, 10'd10, 10'd10, 8'h01, 8'h02);
    apply_settings(4'd8, 4'd0, 4'd8, 10'd320);
    draw_glyph(9'd0, 10'd10, 10'd10, 8'h01, 8'h02);

    // Oversized glyph saturates; its bytes lie past the store; zero stride.
    apply_settings(4'd15, 4'd15, 4'd15, 10'd0);
    draw_glyph(9'd255, 10'd512, 10'd3, 8'h11, 8'h22);

    // No bytes per symbol: every code shares the first glyph.
    apply_settings(4'd8, 4'd8, 4'd0, 10'd1);
    draw_glyph(9'd77, 10'd100, 10'd200, 8'h33, 8'h44);

    // Random phases; the first one runs without any gaps.
    phase = 0;
    while (sent_count < TARGET_REQUESTS) begin
      pauses_on = (phase != 0);
      random_phase($urandom_range(20, 40));
      phase++;
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
